@@ src/rgba_alpha_blend_macros.svh @@
// Assertion macros for the alpha blender.
// Both macros use the module's clk; RAB_ASSERT also holds off while rst is high.
`ifndef RGBA_ALPHA_BLEND_MACROS_SVH
`define RGBA_ALPHA_BLEND_MACROS_SVH

// Checked at every clock edge outside reset
`define RAB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rgba_alpha_blend assertion failed");

// Checked at every clock edge, reset included
`define RAB_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("rgba_alpha_blend assertion failed");

`endif

@@ src/rab_pkg.sv @@
// Shared types and constants for the alpha blender.
// No dependencies; used by rab_front, rab_div_cell, rgba_alpha_blend and the testbench.
`default_nettype none

package rab_pkg;

  localparam int INDEX_BITS_DEF = 20;   // default pixel index width
  localparam int IDX_FIELD_BITS = 20;   // index bits that survive to the result
  localparam int NUM_W          = 17;   // weighted channel sum, up to 255*510
  localparam int DIV_W          = 9;    // divisor: alpha sum, 1 or 256
  localparam int QUO_W          = 8;    // one colour channel
  localparam int LANES          = 3;    // colour channels per pixel
  localparam int ADDR_BITS      = 3;    // APB byte address width

  // Register indexes and mode codes
  localparam logic REG_COLOR_MODE = 1'b0;
  localparam logic MODE_RGB       = 1'b0;
  localparam logic MODE_RGBA      = 1'b1;

  // One colour channel on its way through the divider row
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } rab_lane_t;

  // Everything a cell hands to its neighbor
  typedef struct packed {
    rab_lane_t [LANES-1:0] lane;
    logic [DIV_W-1:0]      div;
    logic [7:0]            alpha;
    logic                  mode;
  } rab_work_t;

endpackage

`default_nettype wire

@@ src/rab_front.sv @@
// Front stage: picks weights and divisor per mode and registers the weighted sums.
// Depends on rab_pkg.
`default_nettype none

module rab_front #(
  parameter int INDEX_BITS = rab_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  color_mode,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [INDEX_BITS-1:0] pixel_index,
  input  logic [31:0]           old_pixel,
  input  logic [31:0]           new_color,
  input  logic [8:0]            blend_alpha,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [INDEX_BITS-1:0] out_idx,
  output rab_pkg::rab_work_t    out_work
);
  import rab_pkg::*;

  localparam int KEEP_BITS = (INDEX_BITS < IDX_FIELD_BITS) ? INDEX_BITS : IDX_FIELD_BITS;
  localparam logic [INDEX_BITS-1:0] IDX_MASK = INDEX_BITS'((64'd1 << KEEP_BITS) - 64'd1);

  logic             ready;
  logic [7:0]       a_old;
  logic [7:0]       a_new;
  logic [8:0]       a_sum;
  logic [8:0]       w_sat;
  logic [8:0]       w_old;
  logic [8:0]       w_new;
  rab_work_t        work_next;
  logic [7:0]       ob [LANES];
  logic [7:0]       nb [LANES];

  assign ready    = !out_valid || !out_stall;
  assign in_stall = !ready;

  assign a_old = old_pixel[7:0];
  assign a_new = new_color[7:0];
  assign a_sum = {1'b0, a_old} + {1'b0, a_new};
  assign w_sat = (blend_alpha > 9'd256) ? 9'd256 : blend_alpha;

  // Pick weights, divisor and channel bytes for the mode
  always_comb begin
    work_next = '0;
    work_next.mode = color_mode;
    if (color_mode == MODE_RGBA) begin
      work_next.alpha = (a_sum > 9'd255) ? 8'd255 : a_sum[7:0];
      if (a_sum == 9'd0) begin
        // both alphas zero: keep the old colour
        w_old = 9'd1;
        w_new = 9'd0;
        work_next.div = 9'd1;
      end else begin
        w_old = {1'b0, a_old};
        w_new = {1'b0, a_new};
        work_next.div = a_sum;
      end
    end else begin
      work_next.alpha = 8'd0;
      w_old = 9'd256 - w_sat;
      w_new = w_sat;
      work_next.div = 9'd256;
    end
    for (int l = 0; l < LANES; l++) begin
      if (color_mode == MODE_RGBA) begin
        ob[l] = old_pixel[31-8*l -: 8];
        nb[l] = new_color[31-8*l -: 8];
      end else begin
        ob[l] = old_pixel[23-8*l -: 8];
        nb[l] = new_color[23-8*l -: 8];
      end
      work_next.lane[l].rem = NUM_W'(ob[l]) * NUM_W'(w_old) + NUM_W'(nb[l]) * NUM_W'(w_new);
      work_next.lane[l].quo = '0;
    end
  end

  // Advance the stage when the next cell can take the item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready) begin
      out_idx  <= pixel_index & IDX_MASK;
      out_work <= work_next;
    end
  end

endmodule

`default_nettype wire

@@ src/rab_div_cell.sv @@
// Divider cell: settles one quotient bit of all three channels and passes the item on.
// Depends on rab_pkg.
`default_nettype none

module rab_div_cell #(
  parameter int INDEX_BITS = rab_pkg::INDEX_BITS_DEF,
  parameter int BIT        = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [INDEX_BITS-1:0] in_idx,
  input  rab_pkg::rab_work_t    in_work,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [INDEX_BITS-1:0] out_idx,
  output rab_pkg::rab_work_t    out_work
);
  import rab_pkg::*;

  logic             ready;
  logic [NUM_W-1:0] trial;
  logic             take [LANES];
  rab_work_t        work_next;

  assign ready    = !out_valid || !out_stall;
  assign in_stall = !ready;
  assign trial    = NUM_W'(in_work.div) << BIT;

  // Compare and subtract the shifted divisor in each channel
  always_comb begin
    work_next = in_work;
    for (int l = 0; l < LANES; l++) begin
      take[l] = in_work.lane[l].rem >= trial;
      if (take[l]) begin
        work_next.lane[l].rem = in_work.lane[l].rem - trial;
      end
      work_next.lane[l].quo = in_work.lane[l].quo | (QUO_W'(take[l]) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready) begin
      out_idx  <= in_idx;
      out_work <= work_next;
    end
  end

endmodule

`default_nettype wire

@@ src/rgba_alpha_blend.sv @@
// Top level of the pixel alpha blender: APB register, front stage, row of divider cells.
// Depends on rab_pkg, rab_front, rab_div_cell and rgba_alpha_blend_macros.svh.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   input    | in_valid / in_stall    | pixel_index, old_pixel, new_color, blend_alpha
//   output   | out_valid / out_stall  | result_index, blended_pixel
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// One item per clock while the output does not stall; after acceptance an item passes
// the front stage register for the weighted sums, then one register per quotient
// bit in the row of eight divider cells.
// Reset clears the stage valid bits and sets color_mode to RGBA; no clearing pass.
// A stall on the output holds the full stages; empty stages still fill.
`default_nettype none
`include "rgba_alpha_blend_macros.svh"

module rgba_alpha_blend #(
  parameter int INDEX_BITS = rab_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rab_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [INDEX_BITS-1:0]         pixel_index,
  input  logic [31:0]                   old_pixel,
  input  logic [31:0]                   new_color,
  input  logic [8:0]                    blend_alpha,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [INDEX_BITS-1:0]         result_index,
  output logic [31:0]                   blended_pixel
);
  import rab_pkg::*;

  localparam int CELLS = QUO_W;

  logic                  color_mode;
  logic                  reg_sel;
  logic                  st_valid [CELLS+1];
  logic                  st_stall [CELLS+1];
  logic [INDEX_BITS-1:0] st_idx   [CELLS+1];
  rab_work_t             st_work  [CELLS+1];
  rab_work_t             last;

  // Register file: one mode bit at index 0
  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= MODE_RGBA;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_COLOR_MODE) begin
      color_mode <= pwdata[0];
    end
  end

  assign prdata = (reg_sel == REG_COLOR_MODE) ? {31'd0, color_mode} : 32'd0;

  // Weighted sums
  rab_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .color_mode (color_mode),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_index(pixel_index),
    .old_pixel  (old_pixel),
    .new_color  (new_color),
    .blend_alpha(blend_alpha),
    .out_valid  (st_valid[0]),
    .out_stall  (st_stall[0]),
    .out_idx    (st_idx[0]),
    .out_work   (st_work[0])
  );

  // Row of divider cells, most significant quotient bit first
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    rab_div_cell #(.INDEX_BITS(INDEX_BITS), .BIT(CELLS-1-k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (st_valid[k]),
      .in_stall (st_stall[k]),
      .in_idx   (st_idx[k]),
      .in_work  (st_work[k]),
      .out_valid(st_valid[k+1]),
      .out_stall(st_stall[k+1]),
      .out_idx  (st_idx[k+1]),
      .out_work (st_work[k+1])
    );
  end

  // Pack the channels in the packing of the item's mode
  assign st_stall[CELLS] = out_stall;
  assign last            = st_work[CELLS];
  assign out_valid       = st_valid[CELLS];
  assign result_index    = st_idx[CELLS];

  always_comb begin
    if (last.mode == MODE_RGBA) begin
      blended_pixel = {last.lane[0].quo, last.lane[1].quo, last.lane[2].quo, last.alpha};
    end else begin
      blended_pixel = {8'd0, last.lane[0].quo, last.lane[1].quo, last.lane[2].quo};
    end
  end

  // Input stalls only when a full row backs up from a stalled output
  `RAB_ASSERT(a_stall_from_out, in_stall |-> (out_valid && out_stall))
  // Leaving reset puts the block in RGBA mode
  `RAB_ASSERT_ALWAYS(a_reset_mode, (!rst && $past(rst)) |-> (color_mode == MODE_RGBA))
  // Every remainder has dropped below the divisor once the last bit is settled
  `RAB_ASSERT(a_rem_done, out_valid |-> (last.lane[0].rem < NUM_W'(last.div)
                                         && last.lane[1].rem < NUM_W'(last.div)
                                         && last.lane[2].rem < NUM_W'(last.div)))

endmodule

`default_nettype wire

@@ tb/rab_blend_checker.sv @@
// Checker for the pixel alpha blender: watches the register port and both item channels,
// predicts each blended pixel and compares it with what the block returns.
// Depends on rab_pkg for the mode codes, register index and address width.
module rab_blend_checker #(
  parameter int IDX_W = rab_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [rab_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [IDX_W-1:0]              pixel_index,
  input  logic [31:0]                   old_pixel,
  input  logic [31:0]                   new_color,
  input  logic [8:0]                    blend_alpha,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [IDX_W-1:0]              result_index,
  input  logic [31:0]                   blended_pixel,
  output int                            mismatches,
  output int                            pixels_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rab_pkg::ADDR_BITS-1:0] MODE_ADDR =
    rab_pkg::ADDR_BITS'({rab_pkg::REG_COLOR_MODE, 2'b00});

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [31:0]      px;
  } blended_t;

  blended_t pending_px[$];
  blended_t want;
  logic     mode_copy;
  int       fail_cnt = 0;
  int       pending_cnt = 0;

  assign mismatches     = fail_cnt;
  assign pixels_pending = pending_cnt;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t mismatch: %s got %08h expected %08h", $realtime, what, got, exp_val);
    fail_cnt++;
  endtask

  // Blend one pixel the way the selected color mode defines it
  function automatic logic [31:0] blend_pixel(input logic mode, input logic [31:0] oldp,
                                              input logic [31:0] newp, input logic [8:0] w);
    int unsigned a_o, a_n, a_sum, wt, ch;
    int k;
    logic [31:0] px;
    px = '0;
    if (mode == rab_pkg::MODE_RGBA) begin
      a_o   = oldp[7:0];
      a_n   = newp[7:0];
      a_sum = a_o + a_n;
      // both alphas zero: keep the old color, alpha stays zero
      if (a_sum == 0)
        return {oldp[31:8], 8'h00};
      for (k = 1; k < 4; k++) begin
        ch = (oldp[8*k +: 8] * a_o + newp[8*k +: 8] * a_n) / a_sum;
        if (ch > 255)
          ch = 255;
        px[8*k +: 8] = ch[7:0];
      end
      // alpha sum saturates at a full byte
      px[7:0] = (a_sum > 255) ? 8'hFF : a_sum[7:0];
    end else begin
      // weights above 256 act as 256; top byte is dropped
      wt = (w > 9'd256) ? 256 : w;
      for (k = 0; k < 3; k++) begin
        ch = (oldp[8*k +: 8] * (256 - wt) + newp[8*k +: 8] * wt) >> 8;
        if (ch > 255)
          ch = 255;
        px[8*k +: 8] = ch[7:0];
      end
    end
    return px;
  endfunction

  // Compare results first, then queue the prediction for a newly accepted item
  always @(posedge clk) begin
    if (rst) begin
      pending_px.delete();
      mode_copy   <= rab_pkg::MODE_RGBA;
      pending_cnt <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_px.size() == 0) begin
          report_mismatch("result with no item pending", blended_pixel, 32'h0);
        end else begin
          want = pending_px.pop_front();
          if (result_index !== want.idx)
            report_mismatch("result_index", 32'(result_index), 32'(want.idx));
          if (blended_pixel !== want.px)
            report_mismatch("blended_pixel", blended_pixel, want.px);
        end
      end
      if (in_valid && !in_stall)
        pending_px.push_back({pixel_index,
                              blend_pixel(mode_copy, old_pixel, new_color, blend_alpha)});
      if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
        mode_copy <= pwdata[0];
      pending_cnt <= pending_px.size();
    end
  end

endmodule

@@ tb/tb_rgba_alpha_blend.sv @@
// Top of the alpha blender testbench: clock, reset, register writes, pixel stimulus
// and the verdict. Depends on rab_pkg, rgba_alpha_blend and rab_blend_checker.
module tb_rgba_alpha_blend;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = rab_pkg::INDEX_BITS_DEF;
  localparam logic [rab_pkg::ADDR_BITS-1:0] MODE_ADDR =
    rab_pkg::ADDR_BITS'({rab_pkg::REG_COLOR_MODE, 2'b00});
  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 116;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel, penable, pwrite, pready;
  logic [rab_pkg::ADDR_BITS-1:0] paddr;
  logic [31:0]                   pwdata, prdata;
  logic                          in_valid, in_stall;
  logic [IDX_W-1:0]              pixel_index;
  logic [31:0]                   old_pixel, new_color;
  logic [8:0]                    blend_alpha;
  logic                          out_valid, out_stall;
  logic [IDX_W-1:0]              result_index;
  logic [31:0]                   blended_pixel;
  int                            blend_errors, pixels_pending;
  int                            gap_max = 15;
  int                            stall_max = 15;

  always #10 clk = ~clk;

  rgba_alpha_blend #(.INDEX_BITS(IDX_W)) dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .pixel_index, .old_pixel, .new_color, .blend_alpha,
    .out_valid, .out_stall, .result_index, .blended_pixel
  );

  rab_blend_checker #(.IDX_W(IDX_W)) u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .pixel_index, .old_pixel, .new_color, .blend_alpha,
    .out_valid, .out_stall, .result_index, .blended_pixel,
    .mismatches(blend_errors), .pixels_pending(pixels_pending)
  );

  // Hold off a random number of cycles, offer one item, wait for acceptance
  task automatic push_pixel(input logic [IDX_W-1:0] idx, input logic [31:0] oldp,
                            input logic [31:0] newc, input logic [8:0] w);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_index <= idx;
    old_pixel   <= oldp;
    new_color   <= newc;
    blend_alpha <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every pending pixel has come back
  task automatic drain_pixels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
  endtask

  // Drain, then write the color mode register with junk in the unused bits
  task automatic write_mode(input logic mode);
    logic [31:0] junk;
    junk = $urandom();
    drain_pixels();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= MODE_ADDR;
    pwdata  <= {junk[31:1], mode};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Alpha byte biased toward zero, full and near-zero values
  function automatic logic [7:0] rand_alpha();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(1, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Weight biased toward the ends and the saturating range
  function automatic logic [8:0] rand_weight();
    case ($urandom_range(0, 7))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(0, 256));
    endcase
  endfunction

  // Result side: stall a random number of cycles before taking each item
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      hold = $urandom_range(0, stall_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Stimulus and verdict
  initial begin
    logic [31:0] r_old, r_new;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    pixel_index = '0;
    old_pixel   = '0;
    new_color   = '0;
    blend_alpha = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // RGBA mode out of reset: zero alpha sum, saturation, one-sided weights
    push_pixel(20'h00000, 32'h00000000, 32'h00000000, 9'd0);
    push_pixel(20'hFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 9'd511);
    push_pixel(20'h12345, 32'h12345600, 32'hABCDEF00, 9'd256);
    push_pixel(20'h00001, 32'h80402000, 32'hC0E0F0FF, 9'd100);
    push_pixel(20'h80000, 32'h102030FF, 32'h00000000, 9'd0);
    push_pixel(20'h7FFFF, 32'hFF00FF80, 32'h00FF0080, 9'd257);
    push_pixel(20'h55555, 32'h0A141E7F, 32'hF0E0D080, 9'd1);
    push_pixel(20'hAAAAA, 32'h00000001, 32'hFFFFFF01, 9'd255);
    push_pixel(20'h0F0F0, 32'hAAAAAA55, 32'h55555555, 9'd128);

    // RGB mode: weight ends, saturating weights, top byte ignored
    write_mode(rab_pkg::MODE_RGB);
    push_pixel(20'h00000, 32'h00FFFFFF, 32'h00000000, 9'd0);
    push_pixel(20'hFFFFF, 32'h00FFFFFF, 32'h00123456, 9'd256);
    push_pixel(20'h00010, 32'hFF102030, 32'hFFA0B0C0, 9'd257);
    push_pixel(20'h00020, 32'h00000000, 32'hFFFFFFFF, 9'd511);
    push_pixel(20'h00030, 32'hFFFFFFFF, 32'h00000000, 9'd128);
    push_pixel(20'h00040, 32'h00000000, 32'hFFFFFFFF, 9'd1);
    push_pixel(20'h00050, 32'hFFFFFFFF, 32'hFFFFFFFF, 9'd255);
    push_pixel(20'hFFFFF, 32'h5A3C1E00, 32'hA5C3E1FF, 9'd300);

    // Random phases: alternate modes, vary the idling on each side
    for (int ph = 0; ph < PHASES; ph++) begin
      write_mode(ph[0] ? rab_pkg::MODE_RGB : rab_pkg::MODE_RGBA);
      case (ph % 4)
        0: begin gap_max = 15; stall_max = 15; end
        1: begin gap_max = 0;  stall_max = 0;  end
        2: begin gap_max = 0;  stall_max = 15; end
        default: begin gap_max = 15; stall_max = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r_old = $urandom();
        r_new = $urandom();
        r_old[7:0] = rand_alpha();
        r_new[7:0] = rand_alpha();
        push_pixel(IDX_W'($urandom()), r_old, r_new, rand_weight());
      end
    end

    // Wait out the pipeline, then give the verdict
    drain_pixels();
    repeat (20) @(posedge clk);
    if (blend_errors == 0)
      $display("PASS rgba_alpha_blend");
    else
      $display("FAIL rgba_alpha_blend");
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #5ms;
    $display("FAIL rgba_alpha_blend");
    $finish;
  end

endmodule
